// ===== rtl/pnq_pkg.sv =====
// Shared types and constants for the palette nearest-color quantizer.
package pnq_pkg;

    localparam int COMP_W  = 8;   // one color component
    localparam int IDX_W   = 8;   // palette index as delivered
    localparam int CNT_W   = 9;   // palette count, 0..256
    localparam int SQ_W    = 16;  // square of a component difference
    localparam int DIST_W  = 20;  // 2*dr^2 + 4*dg^2 + 3*db^2 <= 585225
    localparam int ENTRY_W = 3 * COMP_W;

    // Item kinds on the input channel
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    typedef struct packed {
        logic [COMP_W-1:0] r;
        logic [COMP_W-1:0] g;
        logic [COMP_W-1:0] b;
    } pnq_rgb_t;

    // Status reported by the match unit to the sequencer
    typedef struct packed {
        logic             busy;
        logic             have;
        logic [IDX_W-1:0] best_idx;
    } pnq_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_EMIT
    } pnq_state_t;

    // Absolute difference of two components
    function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                   input logic [COMP_W-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== rtl/palette_nearest_color_quantizer_top.sv =====
// Palette nearest-color quantizer top: sequencer, palette RAM, match unit, result register.
//
// Usage
//   Input words arrive on s_valid/s_ready. A word with s_func = 0 writes
//   palette entry s_entry_slot with {s_red, s_green, s_blue}; slots at or
//   above PALETTE_DEPTH are dropped. A word with s_func = 1 is a pixel and
//   gives exactly one result word on m_valid/m_ready.
//   cfg_wr_en/cfg_wr_data set the number of palette entries searched;
//   change it only while the block is idle.
// Timing
//   Loads can follow each other every cycle while the block is idle.
//   A transparent pixel (alpha zero), or any pixel with an empty palette,
//   skips the search and goes from S_IDLE straight to S_EMIT.
//   Other pixels stream N = min(count, PALETTE_DEPTH) entries through the RAM
//   read port, one per cycle, into a three-stage distance and compare pipeline;
//   the sequencer waits in S_FLUSH until the pipeline has drained, then in S_EMIT
//   until the result register is free; the next word is taken back in S_IDLE.
// Reset and stall
//   Reset clears the count, the sequencer and m_valid; result data and palette
//   are undefined until written. A pixel that finishes while the result register
//   is still full waits in the sequencer, with s_ready low, until m_ready frees it.
module palette_nearest_color_quantizer_top #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_wr_en,
    input  logic [pnq_pkg::CNT_W-1:0]   cfg_wr_data,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_func,
    input  logic [7:0]                  s_entry_slot,
    input  logic [7:0]                  s_red,
    input  logic [7:0]                  s_green,
    input  logic [7:0]                  s_blue,
    input  logic [7:0]                  s_alpha,
    input  logic                        s_frame_end,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_out_red,
    output logic [7:0]                  m_out_green,
    output logic [7:0]                  m_out_blue,
    output logic [7:0]                  m_out_alpha,
    output logic                        m_frame_end_out
);

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam logic [pnq_pkg::CNT_W-1:0] DEPTH_CNT = pnq_pkg::CNT_W'(PALETTE_DEPTH);

    pnq_pkg::pnq_state_t state_reg, state_next;

    logic [pnq_pkg::CNT_W-1:0]  palette_count_reg;
    logic [pnq_pkg::CNT_W-1:0]  limit_reg, limit_next;
    logic [pnq_pkg::CNT_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic                       rd_valid_reg;
    logic [pnq_pkg::IDX_W-1:0]  rd_idx_reg;
    logic                       issue;

    pnq_pkg::pnq_rgb_t          pix_reg;
    logic [7:0]                 alpha_reg;
    logic                       fe_reg;

    logic                       m_valid_reg, m_valid_next;
    logic [7:0]                 out_red_reg, out_green_reg, out_blue_reg, out_alpha_reg;
    logic                       out_fe_reg;
    logic                       load_out;

    logic                       accept;
    logic                       pixel_accept;
    logic                       ram_we;
    logic [pnq_pkg::ENTRY_W-1:0] ram_rdata;
    logic                       clear_best;
    pnq_pkg::pnq_status_t       status;
    logic [7:0]                 result_idx;

    assign s_ready      = (state_reg == pnq_pkg::S_IDLE);
    assign accept       = s_valid && s_ready;
    assign pixel_accept = accept && (s_func == pnq_pkg::FUNC_PIXEL);
    assign ram_we       = accept && (s_func == pnq_pkg::FUNC_LOAD)
                          && ({1'b0, s_entry_slot} < DEPTH_CNT);
    assign clear_best   = pixel_accept;
    assign limit_next   = (palette_count_reg > DEPTH_CNT) ? DEPTH_CNT : palette_count_reg;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_count_reg <= '0;
        end else if (cfg_wr_en) begin
            palette_count_reg <= cfg_wr_data;
        end
    end

    // Palette storage
    pnq_ram #(
        .WIDTH (pnq_pkg::ENTRY_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s_entry_slot[AW-1:0]),
        .wdata ({s_red, s_green, s_blue}),
        .raddr (rd_cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Distance pipeline and minimum search
    pnq_match u_match (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (clear_best),
        .pixel    (pix_reg),
        .in_valid (rd_valid_reg),
        .in_idx   (rd_idx_reg),
        .entry    (ram_rdata),
        .status   (status)
    );

    // Sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pnq_pkg::S_IDLE;
            rd_cnt_reg   <= '0;
            rd_valid_reg <= 1'b0;
            limit_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_cnt_reg   <= rd_cnt_next;
            rd_valid_reg <= issue;
            m_valid_reg  <= m_valid_next;
            if (pixel_accept) begin
                limit_reg <= limit_next;
            end
        end
    end

    // Next state, read issue and result hand-off
    always_comb begin
        state_next   = state_reg;
        rd_cnt_next  = rd_cnt_reg;
        issue        = 1'b0;
        load_out     = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            pnq_pkg::S_IDLE: begin
                rd_cnt_next = '0;
                if (pixel_accept) begin
                    if ((s_alpha == 8'd0) || (limit_next == '0)) begin
                        state_next = pnq_pkg::S_EMIT;
                    end else begin
                        state_next = pnq_pkg::S_SCAN;
                    end
                end
            end
            pnq_pkg::S_SCAN: begin
                issue       = 1'b1;
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if ((rd_cnt_reg + 1'b1) == limit_reg) begin
                    state_next = pnq_pkg::S_FLUSH;
                end
            end
            pnq_pkg::S_FLUSH: begin
                if (!rd_valid_reg && !status.busy) begin
                    state_next = pnq_pkg::S_EMIT;
                end
            end
            pnq_pkg::S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = pnq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = pnq_pkg::S_IDLE;
            end
        endcase
    end

    // Hold the pixel for the search and track the index of each read
    always_ff @(posedge aclk) begin
        if (pixel_accept) begin
            pix_reg   <= '{r: s_red, g: s_green, b: s_blue};
            alpha_reg <= s_alpha;
            fe_reg    <= s_frame_end;
        end
        rd_idx_reg <= rd_cnt_reg[pnq_pkg::IDX_W-1:0];
    end

    // Result register
    assign result_idx = status.best_idx;

    always_ff @(posedge aclk) begin
        if (load_out) begin
            if (alpha_reg == 8'd0) begin
                out_red_reg   <= pix_reg.r;
                out_green_reg <= pix_reg.g;
                out_blue_reg  <= pix_reg.b;
            end else begin
                out_red_reg   <= result_idx;
                out_green_reg <= result_idx;
                out_blue_reg  <= result_idx;
            end
            out_alpha_reg <= alpha_reg;
            out_fe_reg    <= fe_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_red       = out_red_reg;
    assign m_out_green     = out_green_reg;
    assign m_out_blue      = out_blue_reg;
    assign m_out_alpha     = out_alpha_reg;
    assign m_frame_end_out = out_fe_reg;

    // Reads land in the pipeline only while a search is running
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> (state_reg == pnq_pkg::S_SCAN || state_reg == pnq_pkg::S_FLUSH))
        else $error("palette read outside a search");

    // The read counter never passes the captured entry limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_cnt_reg <= limit_reg)
        else $error("read counter beyond palette limit");

    // An opaque pixel over a non-empty palette always has a winner when emitted
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pnq_pkg::S_EMIT && alpha_reg != 8'd0 && limit_reg != '0)
            |-> status.have)
        else $error("result emitted before the search found an entry");

    // A result leaving the sequencer shows up on the output next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (m_valid_reg && state_reg == pnq_pkg::S_IDLE))
        else $error("result word lost on hand-off");

endmodule

// ===== rtl/pnq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module pnq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pnq_match.sv =====
// Distance pipeline and running minimum over streamed palette entries.
module pnq_match (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         clear,
    input  pnq_pkg::pnq_rgb_t            pixel,
    input  logic                         in_valid,
    input  logic [pnq_pkg::IDX_W-1:0]    in_idx,
    input  logic [pnq_pkg::ENTRY_W-1:0]  entry,
    output pnq_pkg::pnq_status_t         status
);

    pnq_pkg::pnq_rgb_t ent;

    logic                        s1_valid_reg;
    logic [pnq_pkg::IDX_W-1:0]   s1_idx_reg;
    logic [pnq_pkg::SQ_W-1:0]    sq_r_reg;
    logic [pnq_pkg::SQ_W-1:0]    sq_g_reg;
    logic [pnq_pkg::SQ_W-1:0]    sq_b_reg;

    logic                        s2_valid_reg;
    logic [pnq_pkg::IDX_W-1:0]   s2_idx_reg;
    logic [pnq_pkg::DIST_W-1:0]  dist_reg;
    logic [pnq_pkg::DIST_W-1:0]  dist_next;

    logic                        have_reg;
    logic [pnq_pkg::DIST_W-1:0]  best_dist_reg;
    logic [pnq_pkg::IDX_W-1:0]   best_idx_reg;
    logic                        take;

    logic [pnq_pkg::COMP_W-1:0]  dr;
    logic [pnq_pkg::COMP_W-1:0]  dg;
    logic [pnq_pkg::COMP_W-1:0]  db;

    assign ent = pnq_pkg::pnq_rgb_t'(entry);
    assign dr  = pnq_pkg::abs_diff(pixel.r, ent.r);
    assign dg  = pnq_pkg::abs_diff(pixel.g, ent.g);
    assign db  = pnq_pkg::abs_diff(pixel.b, ent.b);

    // Stage 1: square the component differences
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
        end
        s1_idx_reg <= in_idx;
        sq_r_reg   <= dr * dr;
        sq_g_reg   <= dg * dg;
        sq_b_reg   <= db * db;
    end

    // Stage 2: weight and sum (2r + 4g + 3b)
    assign dist_next = ({3'b0, sq_r_reg, 1'b0})
                     + ({2'b0, sq_g_reg, 2'b0})
                     + ({3'b0, sq_b_reg, 1'b0})
                     + ({4'b0, sq_b_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
        s2_idx_reg <= s1_idx_reg;
        dist_reg   <= dist_next;
    end

    // Stage 3: keep the earliest entry with the least distance
    assign take = s2_valid_reg && (!have_reg || (dist_reg < best_dist_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg      <= 1'b0;
            best_idx_reg  <= '0;
            best_dist_reg <= '0;
        end else if (clear) begin
            have_reg      <= 1'b0;
            best_idx_reg  <= '0;
            best_dist_reg <= '0;
        end else if (take) begin
            have_reg      <= 1'b1;
            best_idx_reg  <= s2_idx_reg;
            best_dist_reg <= dist_reg;
        end
    end

    assign status.busy     = s1_valid_reg || s2_valid_reg;
    assign status.have     = have_reg;
    assign status.best_idx = best_idx_reg;

    // Check: a new best only ever comes from a valid distance
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!$past(clear) && $past(have_reg) && $past(best_idx_reg) != best_idx_reg)
            |-> $past(s2_valid_reg))
        else $error("best index changed without a valid distance");

endmodule
